@@ rtl/core/rmf_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rmf_pkg: shared types and constants of the row running median filter
// Field widths, register map and the data types that pass between the
// sorting cells and the controller.
// ----------------------------------------------------------------------------
package rmf_pkg;

    localparam int SAMPLE_W    = 17;
    localparam int MEDIAN_W    = 18;
    localparam int COL_OUT_W   = 12;
    localparam int ROW_WIDTH_W = 13;
    localparam int THR_W       = 16;

    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;
    localparam int REG_IDX_LSB = 2;

    localparam logic REG_ROW_WIDTH   = 1'b0;
    localparam logic REG_SPIKE_THR   = 1'b1;

    localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RST = 13'd2160;
    localparam logic [THR_W-1:0]       SPIKE_THR_RST = 16'd5000;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    // One stored sample with its occupancy (or validity) bit.
    typedef struct packed {
        t_sample value;
        logic    occ;
    } t_cell;

    typedef struct packed {
        logic clear;
        logic insert;
        logic shift;
    } t_sort_ctrl;

endpackage
`default_nettype wire

@@ rtl/core/rmf_in_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rmf_in_if: pixel request channel
// Carries one row pixel and its validity bit with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface rmf_in_if;
    import rmf_pkg::*;

    logic    valid;
    logic    ready;
    t_sample sample;
    logic    sample_valid;

    modport source (output valid, output sample, output sample_valid, input ready);
    modport sink   (input valid, input sample, input sample_valid, output ready);
endinterface
`default_nettype wire

@@ rtl/core/rmf_out_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rmf_out_if: median result channel
// Carries one window median with its column, spike flag and row-end marker.
// ----------------------------------------------------------------------------
interface rmf_out_if;
    import rmf_pkg::*;

    logic                        valid;
    logic                        ready;
    logic signed [MEDIAN_W-1:0]  median_x2;
    logic                        median_valid;
    logic        [COL_OUT_W-1:0] center_column;
    logic                        spike_flag;
    logic                        last_of_row;

    modport source (output valid, output median_x2, output median_valid,
                    output center_column, output spike_flag, output last_of_row,
                    input ready);
    modport sink   (input valid, input median_x2, input median_valid,
                    input center_column, input spike_flag, input last_of_row,
                    output ready);
endinterface
`default_nettype wire

@@ rtl/core/rmf_sort_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rmf_sort_cell: one cell of the insertion sorting chain
// Holds one sample. On insert it keeps its value, takes the new sample or
// takes its lower neighbour's value; on shift it takes its upper neighbour's.
// ----------------------------------------------------------------------------
module rmf_sort_cell (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire rmf_pkg::t_sort_ctrl i_ctrl,
    input  wire rmf_pkg::t_sample    i_x,
    input  wire rmf_pkg::t_cell      i_prev,
    input  wire                      i_prev_gt,
    input  wire rmf_pkg::t_cell      i_next,
    output rmf_pkg::t_cell           o_cell,
    output logic                     o_gt
);
    import rmf_pkg::*;

    t_cell r_cell;
    t_cell n_cell;

    assign o_gt   = !r_cell.occ || (r_cell.value > i_x);
    assign o_cell = r_cell;

    always_comb begin
        n_cell = r_cell;
        priority if (i_ctrl.clear) begin
            n_cell.occ = 1'b0;
        end else if (i_ctrl.insert && o_gt) begin
            n_cell = i_prev_gt ? i_prev : t_cell'{value: i_x, occ: 1'b1};
        end else if (i_ctrl.shift) begin
            n_cell = i_next;
        end else begin
            n_cell = r_cell;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cell.value <= n_cell.value;
        if (!i_rst_n) begin
            r_cell.occ <= 1'b0;
        end else begin
            r_cell.occ <= n_cell.occ;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/rmf_sort_chain.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rmf_sort_chain: row of sorting cells
// Keeps the inserted samples in ascending order from cell 0 upwards and
// shifts the row down towards cell 0 to bring the middle values forward.
// ----------------------------------------------------------------------------
module rmf_sort_chain #(
    parameter int N = 21
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire rmf_pkg::t_sort_ctrl i_ctrl,
    input  wire rmf_pkg::t_sample    i_x,
    output rmf_pkg::t_cell           o_lo,
    output rmf_pkg::t_cell           o_lo_next
);
    import rmf_pkg::*;

    t_cell w_cell [N];
    logic  w_gt   [N];

    for (genvar g = 0; g < N; g++) begin : g_cell
        t_cell w_prev;
        t_cell w_next;
        logic  w_prev_gt;

        if (g == 0) begin : g_first
            assign w_prev    = '0;
            assign w_prev_gt = 1'b0;
        end else begin : g_mid
            assign w_prev    = w_cell[g-1];
            assign w_prev_gt = w_gt[g-1];
        end

        if (g == N - 1) begin : g_last
            assign w_next = '0;
        end else begin : g_up
            assign w_next = w_cell[g+1];
        end

        rmf_sort_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctrl    (i_ctrl),
            .i_x       (i_x),
            .i_prev    (w_prev),
            .i_prev_gt (w_prev_gt),
            .i_next    (w_next),
            .o_cell    (w_cell[g]),
            .o_gt      (w_gt[g])
        );
    end

    assign o_lo      = w_cell[0];
    assign o_lo_next = w_cell[1];

endmodule
`default_nettype wire

@@ rtl/core/row_running_median_filter_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// row_running_median_filter_unit: running median over a row with spike flag
// An item without a result passes only the idle state. For each result the
// window streams through the sorting chain, the middle value is shifted to
// the chain's head, the median is formed and the output register is loaded
// when it is empty or being read. No new item is taken until every result of
// the last one is loaded. A row-end item gives up to HALF_WINDOW+1 results
// one after another. Reset (synchronous, active low) empties the window, sets
// the column to zero and loads the register reset values.
// ----------------------------------------------------------------------------
module row_running_median_filter_unit #(
    parameter int HALF_WINDOW   = 10,
    parameter int MAX_ROW_WIDTH = 4096
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    rmf_in_if.sink                             i_pix,
    rmf_out_if.source                          o_res,
    input  wire                                psel,
    input  wire                                penable,
    input  wire                                pwrite,
    input  wire  [rmf_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire  [rmf_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [rmf_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);
    import rmf_pkg::*;

    localparam int W   = 2 * HALF_WINDOW + 1;
    localparam int CW  = $clog2(MAX_ROW_WIDTH);
    localparam int SW  = ((CW > ROW_WIDTH_W) ? CW : ROW_WIDTH_W) + 2;
    localparam int TW  = $clog2(W);
    localparam int NW  = $clog2(W + 1);
    localparam int SHW = $clog2(HALF_WINDOW + 1);
    localparam int SPW = MEDIAN_W + 2;

    localparam logic signed [SW-1:0] S_ONE  = SW'(1);
    localparam logic signed [SW-1:0] S_HALF = SW'(HALF_WINDOW);
    localparam logic signed [SW-1:0] S_WM1  = SW'(W - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_SUM,
        S_EMIT
    } t_state;

    // Registers
    logic [ROW_WIDTH_W-1:0] r_row_width;
    logic [THR_W-1:0]       r_spike_thr;
    t_cell                  r_win [W];

    t_state                     r_state,    n_state;
    logic [CW-1:0]              r_colcnt,   n_colcnt;
    logic [CW-1:0]              r_col,      n_col;
    logic                       r_row_end,  n_row_end;
    logic [CW-1:0]              r_c,        n_c;
    logic [CW-1:0]              r_c_last,   n_c_last;
    logic signed [SW-1:0]       r_j,        n_j;
    logic [TW-1:0]              r_t,        n_t;
    logic [NW-1:0]              r_cnt,      n_cnt;
    logic [SHW-1:0]             r_shift,    n_shift;
    t_cell                      r_ctr,      n_ctr;
    logic signed [MEDIAN_W-1:0] r_mx2,      n_mx2;
    logic                       r_mval,     n_mval;
    logic                       r_out_valid, n_out_valid;
    logic signed [MEDIAN_W-1:0] r_o_mx2,    n_o_mx2;
    logic                       r_o_mval,   n_o_mval;
    logic [COL_OUT_W-1:0]       r_o_col,    n_o_col;
    logic                       r_o_spike,  n_o_spike;
    logic                       r_o_last,   n_o_last;

    // Combinational signals
    logic                 w_accept;
    logic                 w_cfg_wr;
    logic signed [SW-1:0] w_colcnt_s;
    logic signed [SW-1:0] w_col_s;
    logic signed [SW-1:0] w_rw_s;
    logic signed [SW-1:0] w_c_s;
    logic [SW-1:0]        w_c_wide;
    logic                 w_row_end;
    logic                 w_past_half;
    logic                 w_count_it;
    logic signed [SPW-1:0] w_lhs;
    logic signed [SPW-1:0] w_rhs;
    logic                 w_spike;
    t_sort_ctrl           w_ctrl;
    t_cell                w_lo;
    t_cell                w_lo_next;

    // Configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width <= ROW_WIDTH_RST;
            r_spike_thr <= SPIKE_THR_RST;
        end else if (w_cfg_wr) begin
            unique case (paddr[REG_IDX_LSB])
                REG_ROW_WIDTH: r_row_width <= pwdata[ROW_WIDTH_W-1:0];
                REG_SPIKE_THR: r_spike_thr <= pwdata[THR_W-1:0];
                default:       r_row_width <= r_row_width;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[REG_IDX_LSB])
            REG_ROW_WIDTH: prdata = APB_DATA_W'(r_row_width);
            REG_SPIKE_THR: prdata = APB_DATA_W'(r_spike_thr);
            default:       prdata = '0;
        endcase
    end

    // Window: shifts in a new pixel on each request and rotates once per
    // cycle while a result is being scanned, so entry 0 feeds the sorter.
    assign i_pix.ready = (r_state == S_IDLE);
    assign w_accept    = i_pix.valid && i_pix.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < W; k++) begin
                r_win[k].occ <= 1'b0;
            end
        end else if (w_accept || (r_state == S_SCAN)) begin
            for (int k = 0; k < W - 1; k++) begin
                r_win[k] <= r_win[k+1];
            end
            r_win[W-1] <= w_accept ? t_cell'{value: i_pix.sample, occ: i_pix.sample_valid}
                                   : r_win[0];
        end
    end

    rmf_sort_chain #(
        .N (W)
    ) u_chain (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (w_ctrl),
        .i_x       (r_win[0].value),
        .o_lo      (w_lo),
        .o_lo_next (w_lo_next)
    );

    assign w_colcnt_s  = $signed(SW'(r_colcnt));
    assign w_col_s     = $signed(SW'(r_col));
    assign w_rw_s      = $signed(SW'(r_row_width));
    assign w_c_s       = $signed(SW'(r_c));
    assign w_c_wide    = SW'(r_c);
    assign w_row_end   = w_colcnt_s >= (w_rw_s - S_ONE);
    assign w_past_half = r_colcnt >= CW'(HALF_WINDOW);

    assign w_count_it = r_win[0].occ
                     && (r_j >= (w_c_s - S_HALF)) && (r_j <= (w_c_s + S_HALF))
                     && (r_j >= S_HALF) && (r_j <= (w_rw_s - S_HALF - S_ONE));

    assign w_lhs   = SPW'(r_ctr.value) <<< 1;
    assign w_rhs   = SPW'(r_mx2) + $signed(SPW'({r_spike_thr, 1'b0}));
    assign w_spike = r_ctr.occ && r_mval && (w_lhs > w_rhs);

    always_comb begin
        n_state     = r_state;
        n_colcnt    = r_colcnt;
        n_col       = r_col;
        n_row_end   = r_row_end;
        n_c         = r_c;
        n_c_last    = r_c_last;
        n_j         = r_j;
        n_t         = r_t;
        n_cnt       = r_cnt;
        n_shift     = r_shift;
        n_ctr       = r_ctr;
        n_mx2       = r_mx2;
        n_mval      = r_mval;
        n_out_valid = r_out_valid && !o_res.ready;
        n_o_mx2     = r_o_mx2;
        n_o_mval    = r_o_mval;
        n_o_col     = r_o_col;
        n_o_spike   = r_o_spike;
        n_o_last    = r_o_last;
        w_ctrl      = '0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_col     = r_colcnt;
                    n_row_end = w_row_end;
                    if (w_row_end || (r_colcnt == CW'(MAX_ROW_WIDTH - 1))) begin
                        n_colcnt = '0;
                    end else begin
                        n_colcnt = r_colcnt + CW'(1);
                    end
                    if (w_past_half || w_row_end) begin
                        n_state      = S_SCAN;
                        n_c          = w_past_half ? (r_colcnt - CW'(HALF_WINDOW)) : '0;
                        n_c_last     = w_row_end ? r_colcnt : (r_colcnt - CW'(HALF_WINDOW));
                        n_j          = w_colcnt_s - S_WM1;
                        n_t          = '0;
                        n_cnt        = '0;
                        w_ctrl.clear = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                n_j = r_j + S_ONE;
                n_t = r_t + TW'(1);
                if (w_count_it) begin
                    w_ctrl.insert = 1'b1;
                    n_cnt         = r_cnt + NW'(1);
                end
                if (r_j == w_c_s) begin
                    n_ctr = r_win[0];
                end
                if (r_t == TW'(W - 1)) begin
                    n_state = S_SHIFT;
                    n_shift = '0;
                    if (n_cnt != '0) begin
                        n_shift = SHW'((n_cnt - NW'(1)) >> 1);
                    end
                end
            end
            S_SHIFT: begin
                if (r_shift != '0) begin
                    w_ctrl.shift = 1'b1;
                    n_shift      = r_shift - SHW'(1);
                end else begin
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                n_mval = (r_cnt != '0);
                if (r_cnt == '0) begin
                    n_mx2 = '0;
                end else begin
                    n_mx2 = MEDIAN_W'(w_lo.value)
                          + MEDIAN_W'(r_cnt[0] ? w_lo.value : w_lo_next.value);
                end
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid = 1'b1;
                    n_o_mx2     = r_mx2;
                    n_o_mval    = r_mval;
                    n_o_col     = w_c_wide[COL_OUT_W-1:0];
                    n_o_spike   = w_spike;
                    n_o_last    = r_row_end && (r_c == r_col);
                    if (r_c == r_c_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state      = S_SCAN;
                        n_c          = r_c + CW'(1);
                        n_j          = w_col_s - S_WM1;
                        n_t          = '0;
                        n_cnt        = '0;
                        w_ctrl.clear = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_col     <= n_col;
        r_row_end <= n_row_end;
        r_c       <= n_c;
        r_c_last  <= n_c_last;
        r_j       <= n_j;
        r_t       <= n_t;
        r_ctr     <= n_ctr;
        r_mx2     <= n_mx2;
        r_mval    <= n_mval;
        r_o_mx2   <= n_o_mx2;
        r_o_mval  <= n_o_mval;
        r_o_col   <= n_o_col;
        r_o_spike <= n_o_spike;
        r_o_last  <= n_o_last;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_colcnt    <= '0;
            r_cnt       <= '0;
            r_shift     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_colcnt    <= n_colcnt;
            r_cnt       <= n_cnt;
            r_shift     <= n_shift;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.median_x2     = r_o_mx2;
    assign o_res.median_valid  = r_o_mval;
    assign o_res.center_column = r_o_col;
    assign o_res.spike_flag    = r_o_spike;
    assign o_res.last_of_row   = r_o_last;

    // The scan visits every window entry exactly once before the shift phase.
    a_scan_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_t == TW'(W - 1)) |=> (r_state == S_SHIFT))
        else $error("scan did not end after one pass of the window");

    // The sorter never holds more samples than the window has entries.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt <= NW'(W)))
        else $error("sorter sample count exceeds the window length");

    // When samples were counted, the head of the chain holds one of them.
    a_head_occupied: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SUM && r_cnt != '0) |-> w_lo.occ)
        else $error("sorter head empty although samples were inserted");

    // A row end always returns the column counter to zero.
    a_row_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_row_end) |=> (r_colcnt == '0))
        else $error("column counter not cleared at the end of a row");

endmodule
`default_nettype wire

@@ test/row_running_median_filter_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// row_running_median_filter_unit_tb: self-checking bench of the median filter
// Pixel requests go in over the input channel under varying idle and stall
// patterns, and a local window model predicts every median, spike flag and
// row-end marker. Results are checked in order as they leave, and both
// registers are written between phases and read back over the APB port.
// ----------------------------------------------------------------------------
module row_running_median_filter_unit_tb;
    import rmf_pkg::*;

    localparam int HW            = 10;
    localparam int WIN           = 2 * HW + 1;
    localparam int MAXW          = 4096;
    localparam int SETTLE_CYCLES = 4 * (WIN + HW + 4);
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int PHASE_ITEMS   = 28;

    typedef struct {
        logic signed [MEDIAN_W-1:0]  median_x2;
        logic                        median_valid;
        logic        [COL_OUT_W-1:0] center_column;
        logic                        spike_flag;
        logic                        last_of_row;
    } t_median;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    rmf_in_if  pix_if ();
    rmf_out_if res_if ();

    row_running_median_filter_unit #(
        .HALF_WINDOW   (HW),
        .MAX_ROW_WIDTH (MAXW)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Window model: the newest sample sits at the top index.
    t_sample win_sample [WIN];
    logic    win_valid  [WIN];
    int      next_column;
    int      row_width_reg;
    int      spike_thr_reg;

    t_median pending_medians [$];
    int      mismatch_count = 0;
    int      cycle_count    = 0;
    int      src_idle_pct   = 0;
    int      sink_stall_pct = 0;
    int      level          = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("row_running_median_filter_unit_tb: mismatch: %s", msg);
        mismatch_count++;
    endtask

    function automatic void window_median(input int c, input int col, input logic last);
        int      ordered [WIN];
        int      cnt;
        int      hi;
        int      j;
        int      k;
        int      p;
        int      v;
        int      mx2;
        int      kc;
        logic    spike;
        t_median r;
        cnt   = 0;
        mx2   = 0;
        spike = 1'b0;
        hi    = row_width_reg - HW - 1;
        kc    = WIN - 1 - (col - c);
        for (j = c - HW; j <= c + HW; j++) begin
            k = WIN - 1 - (col - j);
            if (j < 0 || j > col || k < 0 || k >= WIN) continue;
            if (j < HW || j > hi || !win_valid[k]) continue;
            v = win_sample[k];
            p = cnt;
            while (p > 0 && ordered[p-1] > v) begin
                ordered[p] = ordered[p-1];
                p--;
            end
            ordered[p] = v;
            cnt++;
        end
        if (cnt > 0) begin
            if (cnt % 2 == 1) begin
                mx2 = 2 * ordered[cnt/2];
            end else begin
                mx2 = ordered[cnt/2-1] + ordered[cnt/2];
            end
            if (win_valid[kc]) begin
                spike = (2 * int'(win_sample[kc])) > (mx2 + 2 * spike_thr_reg);
            end
        end
        r.median_x2     = mx2[MEDIAN_W-1:0];
        r.median_valid  = (cnt > 0);
        r.center_column = c[COL_OUT_W-1:0];
        r.spike_flag    = spike;
        r.last_of_row   = last;
        pending_medians.push_back(r);
    endfunction

    function automatic void advance_window(input t_sample s, input logic ok);
        int   k;
        int   col;
        int   c;
        logic row_end;
        for (k = 0; k < WIN - 1; k++) begin
            win_sample[k] = win_sample[k+1];
            win_valid[k]  = win_valid[k+1];
        end
        win_sample[WIN-1] = s;
        win_valid[WIN-1]  = ok;
        col     = next_column;
        row_end = (col >= row_width_reg - 1);
        if (col >= HW) begin
            window_median(col - HW, col, row_end && HW == 0);
        end
        if (row_end) begin
            c = (col >= HW) ? col - HW + 1 : 0;
            for (; c <= col; c++) begin
                window_median(c, col, c == col);
            end
            next_column = 0;
        end else begin
            next_column++;
            if (next_column >= MAXW) begin
                next_column = 0;
            end
        end
    endfunction

    task automatic push_pixel(input t_sample s, input logic ok);
        while ($urandom_range(99) < src_idle_pct) begin
            pix_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_if.valid        <= 1'b1;
        pix_if.sample       <= s;
        pix_if.sample_valid <= ok;
        do @(posedge i_clk); while (!pix_if.ready);
        advance_window(s, ok);
    endtask

    task automatic pick_sample(output t_sample s, output logic ok);
        int r;
        r  = $urandom_range(99);
        ok = ($urandom_range(99) < 85);
        if (r < 8) begin
            s = t_sample'(65535);
        end else if (r < 16) begin
            s = t_sample'(-65536);
        end else if (r < 60) begin
            s = t_sample'(level + int'($urandom_range(400)) - 200);
        end else if (r < 72) begin
            s = t_sample'(level + int'($urandom_range(5000)));
        end else begin
            s = t_sample'($urandom);
        end
    endtask

    task automatic send_random(input int count);
        t_sample s;
        logic    ok;
        repeat (count) begin
            pick_sample(s, ok);
            push_pixel(s, ok);
        end
    endtask

    task automatic wait_all_results();
        pix_if.valid <= 1'b0;
        while (pending_medians.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_access(input logic idx, input logic wr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= APB_ADDR_W'(idx) << REG_IDX_LSB;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_register(input logic idx, input logic [31:0] want);
        logic [31:0] rd;
        apb_access(idx, 1'b0, '0, rd);
        if (rd !== want) begin
            report_mismatch($sformatf("register %0d reads %0d, expected %0d", idx, rd, want));
        end
    endtask

    task automatic set_register(input logic idx, input int value);
        logic [31:0] rd;
        apb_access(idx, 1'b1, value, rd);
        if (idx == REG_ROW_WIDTH) begin
            row_width_reg = value & ((1 << ROW_WIDTH_W) - 1);
            check_register(idx, row_width_reg);
        end else begin
            spike_thr_reg = value & ((1 << THR_W) - 1);
            check_register(idx, spike_thr_reg);
        end
    endtask

    task automatic reconfigure(input int width, input int thr);
        wait_all_results();
        set_register(REG_ROW_WIDTH, width);
        set_register(REG_SPIKE_THR, thr);
    endtask

    task automatic test_register_reset();
        check_register(REG_ROW_WIDTH, ROW_WIDTH_RST);
        check_register(REG_SPIKE_THR, SPIKE_THR_RST);
    endtask

    // Narrowest row: the centre column alone counts, the borders still
    // compare for spikes, and the row end flushes the last columns at once.
    task automatic test_narrowest_row();
        int j;
        reconfigure(21, 0);
        for (j = 0; j < 21; j++) begin
            if (j == HW) begin
                push_pixel(t_sample'(-65536), 1'b1);
            end else if (j % 2 == 1) begin
                push_pixel(t_sample'(65535), 1'b1);
            end else begin
                push_pixel(t_sample'(j * 1000), 1'b0);
            end
        end
    endtask

    // Rows shorter than the window: nothing counts, so every window is empty.
    task automatic test_short_rows();
        reconfigure(0, 65535);
        push_pixel(t_sample'(12345), 1'b1);
        push_pixel(t_sample'(-1), 1'b1);
        reconfigure(3, 65535);
        push_pixel(t_sample'(65535), 1'b1);
        push_pixel(t_sample'(0), 1'b0);
        push_pixel(t_sample'(-65536), 1'b1);
    endtask

    // Lowering the width below the current column ends the row on the next pixel.
    task automatic test_width_cut_mid_row();
        src_idle_pct   = 19;
        sink_stall_pct = 19;
        level          = -30000;
        reconfigure(4096, 300);
        send_random(40);
        reconfigure(30, 300);
        send_random(40);
    endtask

    task automatic test_random_rows();
        int phase;
        int width;
        int thr;
        for (phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 53; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 53; end
                default: begin src_idle_pct = 19; sink_stall_pct = 19; end
            endcase
            case ($urandom_range(5))
                0: width = 21;
                1: width = $urandom_range(20);
                2: width = 4096;
                default: width = $urandom_range(64, 22);
            endcase
            case ($urandom_range(3))
                0: thr = 0;
                1: thr = 65535;
                2: thr = $urandom_range(200);
                default: thr = $urandom_range(65535);
            endcase
            level = int'($urandom_range(120000)) - 60000;
            reconfigure(width, thr);
            send_random(PHASE_ITEMS / 2);
            if (phase == 3) begin
                wait_all_results();
            end
            send_random(PHASE_ITEMS - PHASE_ITEMS / 2);
        end
    endtask

    always @(posedge i_clk) begin
        t_median want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_medians.size() == 0) begin
                report_mismatch($sformatf("result for column %0d with none pending",
                                          res_if.center_column));
            end else begin
                want = pending_medians.pop_front();
                if (res_if.median_x2 !== want.median_x2)
                    report_mismatch($sformatf("column %0d median_x2 %0d, expected %0d",
                        want.center_column, res_if.median_x2, want.median_x2));
                if (res_if.median_valid !== want.median_valid)
                    report_mismatch($sformatf("column %0d median_valid %b, expected %b",
                        want.center_column, res_if.median_valid, want.median_valid));
                if (res_if.center_column !== want.center_column)
                    report_mismatch($sformatf("center_column %0d, expected %0d",
                        res_if.center_column, want.center_column));
                if (res_if.spike_flag !== want.spike_flag)
                    report_mismatch($sformatf("column %0d spike_flag %b, expected %b",
                        want.center_column, res_if.spike_flag, want.spike_flag));
                if (res_if.last_of_row !== want.last_of_row)
                    report_mismatch($sformatf("column %0d last_of_row %b, expected %b",
                        want.center_column, res_if.last_of_row, want.last_of_row));
            end
        end
        res_if.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("row_running_median_filter_unit_tb: done, errors");
            $finish;
        end
    end

    initial begin
        int k;
        for (k = 0; k < WIN; k++) begin
            win_sample[k] = '0;
            win_valid[k]  = 1'b0;
        end
        next_column   = 0;
        row_width_reg = ROW_WIDTH_RST;
        spike_thr_reg = SPIKE_THR_RST;

        i_rst_n             <= 1'b0;
        pix_if.valid        <= 1'b0;
        pix_if.sample       <= '0;
        pix_if.sample_valid <= 1'b0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_register_reset();
        test_narrowest_row();
        test_short_rows();
        test_width_cut_mid_row();
        test_random_rows();

        wait_all_results();
        if (mismatch_count == 0) begin
            $display("row_running_median_filter_unit_tb: done, clean");
        end else begin
            $display("row_running_median_filter_unit_tb: done, errors");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/rmf_pkg.sv
rtl/core/rmf_in_if.sv
rtl/core/rmf_out_if.sv
rtl/core/rmf_sort_cell.sv
rtl/core/rmf_sort_chain.sv
rtl/core/row_running_median_filter_unit.sv
test/row_running_median_filter_unit_tb.sv
